// File: rtl/dewp_pkg.sv
// Shared types and constants for the digitizer event word parser.
package dewp_pkg;

    // Samples in one complete event
    localparam int SAMPLES_PER_EVENT = 512;
    // Pairs that carry at least one sample of the event
    localparam int MAX_PAIRS = (SAMPLES_PER_EVENT + 1) / 2;
    // Pairs whose odd sample is inside the event
    localparam int FULL_PAIRS = SAMPLES_PER_EVENT / 2;
    // Width of the pair counter, which must hold MAX_PAIRS itself
    localparam int PAIR_W = $clog2(MAX_PAIRS + 1);

    localparam logic [31:0] HEADER_WORD = 32'hFFFF_FFFF;
    localparam logic [15:0] RANGE_LIMIT_RESET = 16'd16384;

    // Command queue depth between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);

    // Result kinds
    localparam logic KIND_PAIR = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // Event status codes
    localparam logic [1:0] STATUS_GOOD = 2'd0;
    localparam logic [1:0] STATUS_RANGE = 2'd1;
    localparam logic [1:0] STATUS_MISSING = 2'd2;

    // Position within the words that follow a header
    typedef enum logic [3:0] {
        POS_IDLE,
        POS_TLOW,
        POS_THIGH,
        POS_ICNT,
        POS_HIT0,
        POS_HIT1,
        POS_EVID,
        POS_FILL,
        POS_DATA
    } pos_t;

    // Commands handed from the front to the back
    typedef enum logic [2:0] {
        OP_TLOW,
        OP_THIGH,
        OP_ICNT,
        OP_EVID,
        OP_SAMPLE,
        OP_CLOSE,
        OP_EOS
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [31:0] word;
    } cmd_t;

    // Push side of the command queue
    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } push_t;

    // Head of the command queue
    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } head_t;

endpackage

// File: rtl/digitizer_event_word_parser.sv
// Top level of the digitizer event word parser.
// Takes one 32-bit digitizer word per cycle and gives at most one result per word:
// a sample pair, or an event summary when a header closes an event or end of
// stream arrives. A word passes the front end (header position tracking) in the
// cycle it is accepted, waits in a four-entry command queue, and the back end
// (event state, sample range check) then loads the result register from the
// queue head. Sustained rate is one word per cycle; the input stalls only when
// the command queue is full, which happens only while the result register is
// held by m_ready low. range_limit resets to 16384; the user must write it through
// cfg_we/cfg_wdata only while the block is idle, which the block does not enforce.
module digitizer_event_word_parser (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_word,
    input  logic        s_end_of_stream,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_result_kind,
    output logic [7:0]  m_pair_index,
    output logic [15:0] m_sample_even,
    output logic [15:0] m_sample_odd,
    output logic [63:0] m_timestamp,
    output logic [31:0] m_event_number,
    output logic [31:0] m_internal_event,
    output logic [1:0]  m_event_status,
    output logic [8:0]  m_pair_count
);
    import dewp_pkg::*;

    push_t push;
    head_t head;
    logic  q_ready;
    logic  pop;

    dewp_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_word          (s_word),
        .s_end_of_stream (s_end_of_stream),
        .q_ready         (q_ready),
        .push            (push)
    );

    dewp_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .q_ready (q_ready),
        .head    (head),
        .pop     (pop)
    );

    dewp_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .head             (head),
        .pop              (pop),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_result_kind    (m_result_kind),
        .m_pair_index     (m_pair_index),
        .m_sample_even    (m_sample_even),
        .m_sample_odd     (m_sample_odd),
        .m_timestamp      (m_timestamp),
        .m_event_number   (m_event_number),
        .m_internal_event (m_internal_event),
        .m_event_status   (m_event_status),
        .m_pair_count     (m_pair_count)
    );

endmodule

// File: rtl/dewp_front.sv
// Front end: accepts words, tracks header position and classifies each item.
module dewp_front (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  logic [31:0]    s_word,
    input  logic           s_end_of_stream,
    input  logic           q_ready,
    output dewp_pkg::push_t push
);
    import dewp_pkg::*;

    pos_t pos_reg, pos_next;
    logic event_seen_reg, event_seen_next;
    logic accept;
    logic is_header;
    logic emit;
    op_t  op;

    assign s_ready   = q_ready;
    assign accept    = s_valid && s_ready;
    assign is_header = (s_word == HEADER_WORD);

    // Next position and event-seen flag
    always_comb begin
        pos_next        = pos_reg;
        event_seen_next = event_seen_reg;
        if (accept) begin
            if (s_end_of_stream) begin
                pos_next        = POS_IDLE;
                event_seen_next = 1'b0;
            end else if (is_header) begin
                pos_next = POS_TLOW;
            end else begin
                case (pos_reg)
                    POS_IDLE:  pos_next = POS_IDLE;
                    POS_TLOW:  pos_next = POS_THIGH;
                    POS_THIGH: pos_next = POS_ICNT;
                    POS_ICNT:  pos_next = POS_HIT0;
                    POS_HIT0:  pos_next = POS_HIT1;
                    POS_HIT1:  pos_next = POS_EVID;
                    POS_EVID: begin
                        pos_next        = POS_FILL;
                        event_seen_next = 1'b1;
                    end
                    POS_FILL:  pos_next = POS_DATA;
                    POS_DATA:  pos_next = POS_DATA;
                    default:   pos_next = POS_IDLE;
                endcase
            end
        end
    end

    // Command for the back end; words that change nothing there are not queued
    always_comb begin
        emit = 1'b0;
        op   = OP_SAMPLE;
        if (s_end_of_stream) begin
            emit = 1'b1;
            op   = OP_EOS;
        end else if (is_header) begin
            emit = event_seen_reg;
            op   = OP_CLOSE;
        end else begin
            case (pos_reg)
                POS_TLOW: begin
                    emit = 1'b1;
                    op   = OP_TLOW;
                end
                POS_THIGH: begin
                    emit = 1'b1;
                    op   = OP_THIGH;
                end
                POS_ICNT: begin
                    emit = 1'b1;
                    op   = OP_ICNT;
                end
                POS_EVID: begin
                    emit = 1'b1;
                    op   = OP_EVID;
                end
                POS_DATA: begin
                    emit = 1'b1;
                    op   = OP_SAMPLE;
                end
                default: begin
                    emit = 1'b0;
                    op   = OP_SAMPLE;
                end
            endcase
        end
    end

    assign push.valid    = accept && emit;
    assign push.cmd.op   = op;
    assign push.cmd.word = s_word;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg        <= POS_IDLE;
            event_seen_reg <= 1'b0;
        end else begin
            pos_reg        <= pos_next;
            event_seen_reg <= event_seen_next;
        end
    end

endmodule

// File: rtl/dewp_queue.sv
// Short command queue between the front end and the back end.
module dewp_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  dewp_pkg::push_t push,
    output logic            q_ready,
    output dewp_pkg::head_t head,
    input  logic            pop
);
    import dewp_pkg::*;

    cmd_t entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;
    logic do_push, do_pop;

    assign q_ready    = (count_reg != (QPTR_W+1)'(QUEUE_DEPTH));
    assign do_push    = push.valid && q_ready;
    assign do_pop     = pop && head.valid;
    assign head.valid = (count_reg != '0);
    assign head.cmd   = entry_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = wr_ptr_reg + QPTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = rd_ptr_reg + QPTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + (QPTR_W+1)'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - (QPTR_W+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push.cmd;
        end
    end

endmodule

// File: rtl/dewp_back.sv
// Back end: holds event state, checks samples and drives the result register.
module dewp_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            cfg_we,
    input  logic [15:0]     cfg_wdata,
    input  dewp_pkg::head_t head,
    output logic            pop,
    output logic            m_valid,
    input  logic            m_ready,
    output logic            m_result_kind,
    output logic [7:0]      m_pair_index,
    output logic [15:0]     m_sample_even,
    output logic [15:0]     m_sample_odd,
    output logic [63:0]     m_timestamp,
    output logic [31:0]     m_event_number,
    output logic [31:0]     m_internal_event,
    output logic [1:0]      m_event_status,
    output logic [8:0]      m_pair_count
);
    import dewp_pkg::*;

    localparam logic [PAIR_W-1:0] MAX_PAIRS_C  = PAIR_W'(MAX_PAIRS);
    localparam logic [PAIR_W-1:0] FULL_PAIRS_C = PAIR_W'(FULL_PAIRS);

    logic [15:0]       range_limit_reg;
    logic [PAIR_W-1:0] pairs_reg, pairs_next;
    logic              range_err_reg, range_err_next;
    logic [31:0]       tlow_reg, tlow_next;
    logic [63:0]       event_time_reg, event_time_next;
    logic [31:0]       icnt_reg, icnt_next;
    logic [31:0]       evid_reg, evid_next;
    logic              out_valid_reg, out_valid_next;

    logic [15:0] even_s, odd_s;
    logic        even_bad, odd_bad;
    logic        is_close, is_sample, pair_room;
    logic        produces, load_out;
    logic [1:0]  status;

    assign even_s    = head.cmd.word[15:0];
    assign odd_s     = head.cmd.word[31:16];
    assign even_bad  = (even_s == '0) || (even_s >= range_limit_reg);
    assign odd_bad   = (odd_s == '0) || (odd_s >= range_limit_reg);
    assign is_close  = (head.cmd.op == OP_CLOSE) || (head.cmd.op == OP_EOS);
    assign is_sample = (head.cmd.op == OP_SAMPLE);
    assign pair_room = (pairs_reg < MAX_PAIRS_C);
    assign produces  = is_close || (is_sample && pair_room);

    // Take the head unless it has a result and the output register is blocked
    assign pop      = head.valid && (!produces || !out_valid_reg || m_ready);
    assign load_out = pop && produces;

    // Missing samples outrank out of range
    always_comb begin
        if (pairs_reg < MAX_PAIRS_C) begin
            status = STATUS_MISSING;
        end else if (range_err_reg) begin
            status = STATUS_RANGE;
        end else begin
            status = STATUS_GOOD;
        end
    end

    // Event state update
    always_comb begin
        pairs_next      = pairs_reg;
        range_err_next  = range_err_reg;
        tlow_next       = tlow_reg;
        event_time_next = event_time_reg;
        icnt_next       = icnt_reg;
        evid_next       = evid_reg;
        if (pop) begin
            case (head.cmd.op)
                OP_TLOW:  tlow_next = head.cmd.word;
                OP_THIGH: event_time_next = {head.cmd.word, tlow_reg};
                OP_ICNT:  icnt_next = head.cmd.word;
                OP_EVID:  evid_next = head.cmd.word;
                OP_SAMPLE: begin
                    if (pair_room) begin
                        pairs_next = pairs_reg + PAIR_W'(1);
                        if (even_bad || ((pairs_reg < FULL_PAIRS_C) && odd_bad)) begin
                            range_err_next = 1'b1;
                        end
                    end
                end
                OP_CLOSE: begin
                    pairs_next      = '0;
                    range_err_next  = 1'b0;
                    event_time_next = '0;
                end
                OP_EOS: begin
                    pairs_next      = '0;
                    range_err_next  = 1'b0;
                    event_time_next = '0;
                    tlow_next       = '0;
                    icnt_next       = '0;
                    evid_next       = '0;
                end
                default: begin
                    pairs_next = pairs_reg;
                end
            endcase
        end
    end

    // Output register valid
    always_comb begin
        if (load_out) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            range_limit_reg <= RANGE_LIMIT_RESET;
            pairs_reg       <= '0;
            range_err_reg   <= 1'b0;
            tlow_reg        <= '0;
            event_time_reg  <= '0;
            icnt_reg        <= '0;
            evid_reg        <= '0;
            out_valid_reg   <= 1'b0;
        end else begin
            if (cfg_we) begin
                range_limit_reg <= cfg_wdata;
            end
            pairs_reg      <= pairs_next;
            range_err_reg  <= range_err_next;
            tlow_reg       <= tlow_next;
            event_time_reg <= event_time_next;
            icnt_reg       <= icnt_next;
            evid_reg       <= evid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (load_out) begin
            if (is_close) begin
                m_result_kind    <= KIND_SUMMARY;
                m_pair_index     <= '0;
                m_sample_even    <= '0;
                m_sample_odd     <= '0;
                m_timestamp      <= event_time_reg;
                m_event_number   <= evid_reg;
                m_internal_event <= icnt_reg;
                m_event_status   <= status;
                m_pair_count     <= 9'(pairs_reg);
            end else begin
                m_result_kind    <= KIND_PAIR;
                m_pair_index     <= 8'(pairs_reg);
                m_sample_even    <= even_s;
                m_sample_odd     <= odd_s;
                m_timestamp      <= '0;
                m_event_number   <= '0;
                m_internal_event <= '0;
                m_event_status   <= STATUS_GOOD;
                m_pair_count     <= '0;
            end
        end
    end

    assign m_valid = out_valid_reg;

endmodule
